### rtl/mvt_pkg.sv
// Shared constants, types and codes for the 4x4 matrix-vector transform block.
// Used by mvt_row_pipe, matrix_vector_transform_4x4_top and mvt_checker.
// No dependencies.
package mvt_pkg;

  // Matrix dimension and fixed-point format of coefficients and vectors.
  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;

  // The ports carry four vector components and four result components.
  localparam int NUM_VEC = 4;

  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int PAIRS  = (DIM + 1) / 2;
  localparam int PAIR_W = PROD_W + 1;
  localparam int ACC_W  = PROD_W + $clog2(DIM);
  // Top bits of the sum that must all agree for the shifted value to fit.
  localparam int SAT_W  = ACC_W - FRAC_BITS - DATA_W + 1;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam data_t DATA_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam data_t COEFF_ONE = DATA_W'(1) << FRAC_BITS;

  // Beat kinds on the input channel.
  typedef enum logic [0:0] {
    KIND_LOAD      = 1'b0,
    KIND_TRANSFORM = 1'b1
  } kind_e;

  // Per-stage load enables for the row datapaths.
  typedef struct packed {
    logic mul;
    logic pair;
    logic acc;
    logic out;
  } pipe_en_t;

endpackage

### rtl/matrix_vector_transform_4x4_top.sv
// Channel  | Direction | Handshake                 | Payload
// input    | in        | in_valid_i / in_stall_o   | kind, row, col, coeff, vec_x..vec_w
// output   | out       | out_valid_o / out_stall_i | out_x..out_w, saturated
//
// A transform beat passes the product, pair, sum and output registers in turn.
// The four-stage row pipeline (multiply, pair add, final add, saturate) takes
// one beat per cycle when not stalled; a load beat writes the matrix in the
// cycle it is taken. Reset sets the matrix to identity and empties the pipeline.
// Output stalls hold each stage until the next one frees up; bubbles collapse.
//
// Top level of the transform block; depends on mvt_pkg and mvt_row_pipe.
module matrix_vector_transform_4x4_top import mvt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [1:0]  row_i,
  input  logic [1:0]  col_i,
  input  data_t       coeff_i,
  input  data_t       vec_x_i,
  input  data_t       vec_y_i,
  input  data_t       vec_z_i,
  input  data_t       vec_w_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output data_t       out_x_o,
  output data_t       out_y_o,
  output data_t       out_z_o,
  output data_t       out_w_o,
  output logic        saturated_o
);

  data_t    coeff_q [DIM][DIM];
  data_t    vec_in  [NUM_VEC];
  data_t    vec     [DIM];
  data_t    row_res [DIM];
  logic     [DIM-1:0] row_sat;
  data_t    out_comp [NUM_VEC];

  logic     v1_q, v2_q, v3_q, out_valid_q;
  logic     v1_d, v2_d, v3_d, out_valid_d;
  logic     ready1, ready2, ready3, ready4;
  logic     take_xf, take_load;
  pipe_en_t en;

  // Backpressure chain: a stage may load when empty or when it drains.
  assign ready4 = !out_valid_q || !out_stall_i;
  assign ready3 = !v3_q || ready4;
  assign ready2 = !v2_q || ready3;
  assign ready1 = !v1_q || ready2;

  assign in_stall_o = !ready1;
  assign take_xf    = in_valid_i && ready1 && (kind_i == KIND_TRANSFORM);
  assign take_load  = in_valid_i && ready1 && (kind_i == KIND_LOAD);

  assign en.mul  = take_xf;
  assign en.pair = ready2 && v1_q;
  assign en.acc  = ready3 && v2_q;
  assign en.out  = ready4 && v3_q;

  // Valid bits move with the data.
  always_comb begin
    v1_d        = ready1 ? take_xf : v1_q;
    v2_d        = ready2 ? v1_q    : v2_q;
    v3_d        = ready3 ? v2_q    : v3_q;
    out_valid_d = ready4 ? v3_q    : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      v3_q        <= v3_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Coefficient matrix; a load beat outside the matrix is dropped.
  for (genvar r = 0; r < DIM; r++) begin : g_mrow
    for (genvar c = 0; c < DIM; c++) begin : g_mcol
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          coeff_q[r][c] <= (r == c) ? COEFF_ONE : '0;
        end else if (take_load && (32'(row_i) == 32'(r)) && (32'(col_i) == 32'(c))) begin
          coeff_q[r][c] <= coeff_i;
        end
      end
    end
  end

  // Vector components beyond the port set read as zero.
  assign vec_in[0] = vec_x_i;
  assign vec_in[1] = vec_y_i;
  assign vec_in[2] = vec_z_i;
  assign vec_in[3] = vec_w_i;

  for (genvar c = 0; c < DIM; c++) begin : g_vec
    if (c < NUM_VEC) begin : g_port
      assign vec[c] = vec_in[c];
    end else begin : g_zero
      assign vec[c] = '0;
    end
  end

  // One datapath per matrix row.
  for (genvar r = 0; r < DIM; r++) begin : g_row
    mvt_row_pipe u_row (
      .clk_i    (clk_i),
      .en_i     (en),
      .coeff_i  (coeff_q[r]),
      .vec_i    (vec),
      .result_o (row_res[r]),
      .sat_o    (row_sat[r])
    );
  end

  // Result components beyond the matrix size are zero.
  for (genvar i = 0; i < NUM_VEC; i++) begin : g_out
    if (i < DIM) begin : g_row_res
      assign out_comp[i] = row_res[i];
    end else begin : g_zero
      assign out_comp[i] = '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_comp[0];
  assign out_y_o     = out_comp[1];
  assign out_z_o     = out_comp[2];
  assign out_w_o     = out_comp[3];
  assign saturated_o = |row_sat;

endmodule

### rtl/mvt_row_pipe.sv
// One matrix row of the transform datapath: multiply, pair add, final add,
// then shift and saturate. Depends on mvt_pkg; stage control comes from the top.
module mvt_row_pipe import mvt_pkg::*; (
  input  logic     clk_i,
  input  pipe_en_t en_i,
  input  data_t    coeff_i [DIM],
  input  data_t    vec_i   [DIM],
  output data_t    result_o,
  output logic     sat_o
);

  prod_t prod_q [DIM];
  pair_t pair_q [PAIRS];
  acc_t  acc_q;
  acc_t  acc_d;
  data_t result_q;
  data_t result_d;
  logic  sat_q;
  logic  sat_d;
  logic [SAT_W-1:0] top_bits;

  // Stage one: exact signed products of the row with the vector.
  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      for (int c = 0; c < DIM; c++) begin
        prod_q[c] <= PROD_W'(coeff_i[c]) * PROD_W'(vec_i[c]);
      end
    end
  end

  // Stage two: add the products in pairs.
  for (genvar p = 0; p < PAIRS; p++) begin : g_pair
    if (2 * p + 1 < DIM) begin : g_two
      always_ff @(posedge clk_i) begin
        if (en_i.pair) begin
          pair_q[p] <= PAIR_W'(prod_q[2*p]) + PAIR_W'(prod_q[2*p+1]);
        end
      end
    end else begin : g_one
      always_ff @(posedge clk_i) begin
        if (en_i.pair) begin
          pair_q[p] <= PAIR_W'(prod_q[2*p]);
        end
      end
    end
  end

  // Stage three: sum of the pairs at full width.
  always_comb begin
    acc_d = '0;
    for (int p = 0; p < PAIRS; p++) begin
      acc_d = acc_d + ACC_W'(pair_q[p]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.acc) begin
      acc_q <= acc_d;
    end
  end

  // Stage four: drop the fraction bits (floor) and clamp to the data width.
  always_comb begin
    top_bits = acc_q[ACC_W-1:FRAC_BITS+DATA_W-1];
    if ((top_bits == '0) || (top_bits == '1)) begin
      result_d = acc_q[FRAC_BITS+DATA_W-1:FRAC_BITS];
      sat_d    = 1'b0;
    end else begin
      result_d = acc_q[ACC_W-1] ? DATA_MIN : DATA_MAX;
      sat_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.out) begin
      result_q <= result_d;
      sat_q    <= sat_d;
    end
  end

  assign result_o = result_q;
  assign sat_o    = sat_q;

endmodule

### rtl/mvt_checker.sv
// Port-level checks for the transform block, bound to the top level.
// Depends on mvt_pkg.
module mvt_port_checker import mvt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        kind_i,
  input logic [1:0]  row_i,
  input logic [1:0]  col_i,
  input data_t       coeff_i,
  input data_t       vec_x_i,
  input data_t       vec_y_i,
  input data_t       vec_z_i,
  input data_t       vec_w_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input data_t       out_x_o,
  input data_t       out_y_o,
  input data_t       out_z_o,
  input data_t       out_w_o,
  input logic        saturated_o
);

  // A stalled output beat stays in place with the same contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_x_o) && $stable(out_y_o)
      && $stable(out_z_o) && $stable(out_w_o) && $stable(saturated_o))
    else $error("output beat changed while stalled");

  // Without output backpressure the pipeline never stalls its input.
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output is free");

  // A transform beat that is taken must be followed by a valid output beat.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (kind_i == KIND_TRANSFORM) |-> ##4 out_valid_o)
    else $error("transform beat did not reach the output");

  // A saturated result carries at least one clamped component.
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (out_x_o == DATA_MAX) || (out_x_o == DATA_MIN) ||
      (out_y_o == DATA_MAX) || (out_y_o == DATA_MIN) ||
      (out_z_o == DATA_MAX) || (out_z_o == DATA_MIN) ||
      (out_w_o == DATA_MAX) || (out_w_o == DATA_MIN))
    else $error("saturation flag without a clamped component");

endmodule

bind matrix_vector_transform_4x4_top mvt_port_checker u_mvt_checker (.*);

### tb/mvt_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the 4x4 transform block: watches both channels, keeps its own
// copy of the matrix, predicts every transform beat and compares the results.
// Depends on mvt_pkg.
module mvt_checker import mvt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       kind_i,
  input  logic [1:0] row_i,
  input  logic [1:0] col_i,
  input  data_t      coeff_i,
  input  data_t      vec_x_i,
  input  data_t      vec_y_i,
  input  data_t      vec_z_i,
  input  data_t      vec_w_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  data_t      out_x_i,
  input  data_t      out_y_i,
  input  data_t      out_z_i,
  input  data_t      out_w_i,
  input  logic       saturated_i,
  output int         pending_o,
  output int         fail_count_o
);

  // Wide enough to hold the exact sum of four full products.
  typedef logic signed [PROD_W+7:0] wide_t;

  typedef struct packed {
    data_t x;
    data_t y;
    data_t z;
    data_t w;
    logic  sat;
  } vertex_t;

  localparam wide_t WIDE_MAX = DATA_MAX;
  localparam wide_t WIDE_MIN = DATA_MIN;

  data_t   matrix_q [DIM][DIM];
  vertex_t vertex_q [$];
  vertex_t want;
  int      mismatches;

  // Multiplies the current matrix by one vector: exact sum, floor shift, clamp.
  function automatic vertex_t transform_vertex(input data_t vx, input data_t vy,
                                               input data_t vz, input data_t vw);
    data_t   vec  [NUM_VEC];
    data_t   comp [NUM_VEC];
    wide_t   sum;
    wide_t   a;
    wide_t   b;
    vertex_t res;
    int      r;
    int      c;
    vec[0] = vx;
    vec[1] = vy;
    vec[2] = vz;
    vec[3] = vw;
    res.sat = 1'b0;
    for (r = 0; r < NUM_VEC; r++) begin
      comp[r] = '0;
      if (r < DIM) begin
        sum = '0;
        for (c = 0; c < DIM; c++) begin
          a = matrix_q[r][c];
          if (c < NUM_VEC) b = vec[c];
          else b = '0;
          sum = sum + a * b;
        end
        sum = sum >>> FRAC_BITS;
        if (sum > WIDE_MAX) begin
          comp[r] = DATA_MAX;
          res.sat = 1'b1;
        end else if (sum < WIDE_MIN) begin
          comp[r] = DATA_MIN;
          res.sat = 1'b1;
        end else begin
          comp[r] = sum[DATA_W-1:0];
        end
      end
    end
    res.x = comp[0];
    res.y = comp[1];
    res.z = comp[2];
    res.w = comp[3];
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [DATA_W-1:0] exp_val,
                               input logic [DATA_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // Output beats are checked before input beats are predicted, so a result
  // always pairs with a transform taken on an earlier edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          matrix_q[r][c] = (r == c) ? COEFF_ONE : data_t'(0);
        end
      end
      vertex_q.delete();
      mismatches = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (vertex_q.size() == 0) begin
          $error("result beat with no transform waiting");
          mismatches++;
        end else begin
          want = vertex_q.pop_front();
          compare_field("out_x", want.x, out_x_i);
          compare_field("out_y", want.y, out_y_i);
          compare_field("out_z", want.z, out_z_i);
          compare_field("out_w", want.w, out_w_i);
          compare_field("saturated", DATA_W'(want.sat), DATA_W'(saturated_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (kind_i == KIND_LOAD) begin
          // A load outside the matrix is dropped.
          if (row_i < DIM && col_i < DIM) matrix_q[row_i][col_i] = coeff_i;
        end else begin
          vertex_q.push_back(transform_vertex(vec_x_i, vec_y_i, vec_z_i, vec_w_i));
        end
      end
    end
    pending_o    <= vertex_q.size();
    fail_count_o <= mismatches;
  end

endmodule

### tb/matrix_vector_transform_4x4_top_test.sv
`timescale 1ns / 100ps
// Top of the transform block's testbench: clock, reset, stimulus and verdict.
// Depends on mvt_pkg, matrix_vector_transform_4x4_top and mvt_checker.
module matrix_vector_transform_4x4_top_test;
  import mvt_pkg::*;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  kind_e      kind      = KIND_LOAD;
  logic [1:0] row       = '0;
  logic [1:0] col       = '0;
  data_t      coeff     = '0;
  data_t      vec_x     = '0;
  data_t      vec_y     = '0;
  data_t      vec_z     = '0;
  data_t      vec_w     = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  data_t      out_x;
  data_t      out_y;
  data_t      out_z;
  data_t      out_w;
  logic       saturated;
  int         pending;
  int         fail_count;
  bit         calm      = 1'b0;

  matrix_vector_transform_4x4_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .kind_i      (kind),
    .row_i       (row),
    .col_i       (col),
    .coeff_i     (coeff),
    .vec_x_i     (vec_x),
    .vec_y_i     (vec_y),
    .vec_z_i     (vec_z),
    .vec_w_i     (vec_w),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .out_z_o     (out_z),
    .out_w_o     (out_w),
    .saturated_o (saturated)
  );

  mvt_checker u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .kind_i       (kind),
    .row_i        (row),
    .col_i        (col),
    .coeff_i      (coeff),
    .vec_x_i      (vec_x),
    .vec_y_i      (vec_y),
    .vec_z_i      (vec_z),
    .vec_w_i      (vec_w),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_x_i      (out_x),
    .out_y_i      (out_y),
    .out_z_i      (out_z),
    .out_w_i      (out_w),
    .saturated_i  (saturated),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Idle length: zero most of the time, mostly short otherwise, now and then long.
  function automatic int gap_len(input int idle_pct);
    if (calm || $urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) != 0) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Q16.16 value: mostly within +/- 2^(mag_exp-16), with some full-range values
  // and the corner values.
  function automatic data_t rand_q16(input int mag_exp);
    case ($urandom_range(9))
      0, 1: return data_t'($urandom);
      2: begin
        case ($urandom_range(4))
          0:       return DATA_MAX;
          1:       return DATA_MIN;
          2:       return '0;
          3:       return COEFF_ONE;
          default: return -COEFF_ONE;
        endcase
      end
      default: return data_t'($urandom_range(0, (1 << (mag_exp + 1)) - 1))
                      - data_t'(1 << mag_exp);
    endcase
  endfunction

  // Presents one beat after a random gap and holds it until it is taken.
  task automatic drive_beat(input kind_e k, input logic [1:0] r, input logic [1:0] c,
                            input data_t cf, input data_t x, input data_t y,
                            input data_t z, input data_t w);
    int gap;
    gap = gap_len(35);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    row      <= r;
    col      <= c;
    coeff    <= cf;
    vec_x    <= x;
    vec_y    <= y;
    vec_z    <= z;
    vec_w    <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // Vector fields of a load carry noise; the block must ignore them.
  task automatic load_coeff(input logic [1:0] r, input logic [1:0] c, input data_t cf);
    drive_beat(KIND_LOAD, r, c, cf, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Load fields of a transform carry noise as well.
  task automatic transform(input data_t x, input data_t y, input data_t z, input data_t w);
    drive_beat(KIND_TRANSFORM, 2'($urandom_range(3)), 2'($urandom_range(3)), $urandom,
               x, y, z, w);
  endtask

  // Output stall: random bursts, never back to back; the stall drops between them.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      n = gap_len(30);
      if (n == 0) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin
    int i;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Identity matrix passes the corner values straight through.
    transform(DATA_MAX, DATA_MIN, '0, -32'sd1);
    transform(COEFF_ONE, -COEFF_ONE, 32'sd1, 32'sh0001_8000);

    // Row 0 all at maximum: large vectors clamp high, then low.
    load_coeff(2'd0, 2'd0, DATA_MAX);
    load_coeff(2'd0, 2'd1, DATA_MAX);
    load_coeff(2'd0, 2'd2, DATA_MAX);
    load_coeff(2'd0, 2'd3, DATA_MAX);
    transform(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
    transform(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);

    // Most negative times most negative overflows upward.
    load_coeff(2'd1, 2'd1, DATA_MIN);
    transform(DATA_MIN, DATA_MIN, '0, '0);

    // One half times one LSB: the shift floors toward minus infinity.
    load_coeff(2'd2, 2'd2, 32'sh0000_8000);
    transform('0, '0, 32'sd1, '0);
    transform('0, '0, -32'sd1, '0);

    // Off-diagonal negative coefficient.
    load_coeff(2'd3, 2'd0, -COEFF_ONE);
    transform(32'sh0005_0000, '0, '0, 32'sh0003_0000);

    // Back to a well-behaved matrix before the random part.
    load_coeff(2'd0, 2'd0, COEFF_ONE);
    load_coeff(2'd0, 2'd1, '0);
    load_coeff(2'd0, 2'd2, '0);
    load_coeff(2'd0, 2'd3, '0);
    load_coeff(2'd1, 2'd1, COEFF_ONE);
    transform(rand_q16(24), rand_q16(24), rand_q16(24), rand_q16(24));

    // Random mix of loads and transforms, with calm stretches now and then.
    for (i = 0; i < 1950; i++) begin
      if (i % 150 == 0) calm <= ($urandom_range(3) == 0);
      if ($urandom_range(9) < 3) begin
        load_coeff(2'($urandom_range(3)), 2'($urandom_range(3)), rand_q16(18));
      end else begin
        transform(rand_q16(24), rand_q16(24), rand_q16(24), rand_q16(24));
      end
    end
    in_valid <= 1'b0;

    // Drain: let the last beat reach the checker, then wait for every result.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
rtl/mvt_pkg.sv
rtl/mvt_row_pipe.sv
rtl/matrix_vector_transform_4x4_top.sv
rtl/mvt_checker.sv
tb/mvt_checker.sv
tb/matrix_vector_transform_4x4_top_test.sv
